// ----- src/oas_pkg.sv -----
// Package for the overlap-add synthesis block: field widths, register
// indexes, reset values and the command record passed from front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package oas_pkg;

  localparam int MAX_WINDOW_DEF = 2048;

  localparam int SampleW  = 16;
  localparam int WinCfgW  = 12;
  localparam int HopCfgW  = 11;
  localparam int GainCfgW = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int ProdW    = 33;
  localparam int ScaledW  = 18;
  localparam int SumW     = 19;

  localparam logic [CfgIdxW-1:0] CfgWindow = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHop    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGain   = 2'd2;

  localparam logic [WinCfgW-1:0]  WindowRst = 12'd1024;
  localparam logic [HopCfgW-1:0]  HopRst    = 11'd256;
  localparam logic [GainCfgW-1:0] GainRst   = 16'd16384;

  typedef struct packed {
    logic                      is_out;
    logic                      last;
    logic signed [SampleW-1:0] sample;
  } cmd_t;

  localparam int CmdW = $bits(cmd_t);

endpackage

`default_nettype wire

// ----- src/oas_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module oas_ram #(
  parameter int Width = 16,
  parameter int Depth = 2048,
  localparam int AW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/oas_queue.sv -----
// Two-entry request queue between the front and back parts.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module oas_queue #(
  parameter int Width = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] pop_data_o
);

  logic [Width-1:0] buf_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = buf_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/oas_front.sv -----
// Front part: accepts grain samples, tracks grain position and ring base,
// computes the store address and classifies each request. Uses oas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oas_front import oas_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int AW = $clog2(MAX_WINDOW)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [WinCfgW-1:0] window_i,
  input  wire logic [HopCfgW-1:0] hop_i,
  input  wire logic               busy_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [SampleW-1:0] s_axis_tdata,
  input  wire logic               q_ready_i,
  output logic                    q_valid_o,
  output logic      [AW-1:0]      q_addr_o,
  output cmd_t                    q_cmd_o
);

  localparam int WW = AW + 1;
  localparam int CW = (WW > WinCfgW) ? WW : WinCfgW;

  logic [AW-1:0] pos_q, base_q;
  logic [CW-1:0] win_ext, max_ext, w_c, hop2;
  logic [WW-1:0] w_eff, sum_a, pos_inc, base_sum;
  logic [AW-1:0] h_eff, pos, base, base_nx;
  logic          wrap, accept;

  assign win_ext = CW'(window_i);
  assign max_ext = CW'(MAX_WINDOW);
  assign w_c = (win_ext < CW'(2)) ? CW'(2) : ((win_ext > max_ext) ? max_ext : win_ext);
  assign w_eff = WW'(w_c);
  assign hop2 = CW'({hop_i, 1'b0});
  assign h_eff = (hop_i == '0 || w_c < hop2) ? AW'(w_eff >> 1) : AW'(hop_i);

  assign pos  = (WW'(pos_q) >= w_eff) ? '0 : pos_q;
  assign base = (WW'(base_q) >= w_eff) ? '0 : base_q;

  assign sum_a    = WW'(base) + WW'(pos);
  assign q_addr_o = (sum_a >= w_eff) ? AW'(sum_a - w_eff) : AW'(sum_a);

  assign pos_inc  = WW'(pos) + WW'(1);
  assign wrap     = (pos_inc >= w_eff);
  assign base_sum = WW'(base) + WW'(h_eff);
  assign base_nx  = (base_sum >= w_eff) ? AW'(base_sum - w_eff) : AW'(base_sum);

  assign q_cmd_o.is_out = (pos < h_eff);
  assign q_cmd_o.last   = (pos == AW'(h_eff - AW'(1)));
  assign q_cmd_o.sample = $signed(s_axis_tdata);

  assign s_axis_tready = q_ready_i && !busy_i;
  assign q_valid_o     = s_axis_tvalid && !busy_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      base_q <= '0;
    end else if (accept) begin
      pos_q  <= wrap ? '0 : AW'(pos_inc);
      base_q <= wrap ? base_nx : base;
    end
  end

endmodule

`default_nettype wire

// ----- src/oas_back.sv -----
// Back part: clears the overlap store after reset, then runs the scale,
// read-modify-write and saturation pipeline and holds the output register.
// Uses oas_pkg and oas_ram.
`timescale 1ns / 1ps
`default_nettype none

module oas_back import oas_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int AW = $clog2(MAX_WINDOW)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [GainCfgW-1:0] gain_i,
  output logic                     busy_o,
  input  wire logic                q_valid_i,
  input  wire logic [AW-1:0]       q_addr_i,
  input  wire cmd_t                q_cmd_i,
  output logic                     q_pop_o,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [SampleW-1:0]  m_axis_tdata,
  output logic                     m_axis_tlast
);

  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;

  logic                      s1_valid_q, s1_is_out_q, s1_last_q, s1_fwd_q;
  logic [AW-1:0]             s1_addr_q;
  logic signed [ProdW-1:0]   s1_prod_q;
  logic signed [SampleW-1:0] s1_fwd_data_q;

  logic                      out_valid_q, out_last_q;
  logic [SampleW-1:0]        out_data_q;

  logic signed [ProdW-1:0]   smp_ext, gain_ext, prod_d;
  logic signed [ScaledW-1:0] scaled;
  logic signed [SampleW-1:0] old_val, sat_val, item_wdata;
  logic signed [SumW-1:0]    sum;
  logic [SampleW-1:0]        rdata;
  logic                      out_free, s1_fire, pop;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [SampleW-1:0]        ram_wdata;

  assign smp_ext  = ProdW'(q_cmd_i.sample);
  assign gain_ext = ProdW'($signed({1'b0, gain_i}));
  assign prod_d   = smp_ext * gain_ext + ProdW'(16384);

  assign out_free = !out_valid_q || m_axis_tready;
  assign s1_fire  = s1_valid_q && (!s1_is_out_q || out_free);
  assign pop      = q_valid_i && !clr_q && (!s1_valid_q || s1_fire);
  assign q_pop_o  = pop;
  assign busy_o   = clr_q;

  assign old_val = s1_fwd_q ? s1_fwd_data_q : $signed(rdata);
  assign scaled  = ScaledW'(s1_prod_q >>> 15);
  assign sum     = SumW'(old_val) + SumW'(scaled);

  always_comb begin
    if (sum > SumW'(32767)) begin
      sat_val = 16'sh7fff;
    end else if (sum < -SumW'(32768)) begin
      sat_val = 16'sh8000;
    end else begin
      sat_val = sum[SampleW-1:0];
    end
  end

  assign item_wdata = s1_is_out_q ? '0 : sat_val;
  assign ram_we     = clr_q || s1_fire;
  assign ram_waddr  = clr_q ? clr_cnt_q : s1_addr_q;
  assign ram_wdata  = clr_q ? '0 : item_wdata;

  oas_ram #(
    .Width(SampleW),
    .Depth(MAX_WINDOW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (pop),
    .raddr_i(q_addr_i),
    .rdata_o(rdata)
  );

  // store clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(MAX_WINDOW - 1)) clr_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire && s1_is_out_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_addr_q     <= q_addr_i;
      s1_is_out_q   <= q_cmd_i.is_out;
      s1_last_q     <= q_cmd_i.last;
      s1_prod_q     <= prod_d;
      // same address written this cycle: the RAM read sees stale data
      s1_fwd_q      <= s1_fire && (s1_addr_q == q_addr_i);
      s1_fwd_data_q <= item_wdata;
    end
    if (s1_fire && s1_is_out_q) begin
      out_data_q <= sat_val;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- src/overlap_add_synthesis.sv -----
// Overlap-add synthesis stage: top level with configuration registers,
// front part, request queue and back part. Uses oas_pkg, oas_front,
// oas_queue and oas_back.
//
// Usage:
//   Grain samples enter on the s_axis channel, one signed 16-bit sample per
//   request. The first hop samples of each grain leave on m_axis as the
//   overlap-added, saturated sample; tlast marks the last one of the hop.
//   Later samples of the grain only update the overlap store, no output.
//   Configuration (window, hop, gain) is written through cfg_we_i,
//   cfg_idx_i, cfg_data_i while the block is idle.
//   Throughput: one sample per cycle unless the store clear or a receiver
//   stall holds it; the store is a single RAM with one read and one write
//   port, read on pop from the queue and written as the request leaves s1.
//   Reset: all counters clear and the overlap store is swept to zero, one
//   entry per cycle, through all of it; s_axis_tready stays low meanwhile.
//   Receiver stall: the output register holds; the back pipeline and the
//   two-entry queue fill, then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module overlap_add_synthesis import oas_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [SampleW-1:0]  s_axis_tdata,  // [15:0] grain_sample
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [SampleW-1:0]  m_axis_tdata,  // [15:0] out_sample
  output logic                     m_axis_tlast   // end_of_hop
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int QW = AW + CmdW;

  logic [WinCfgW-1:0]  window_q;
  logic [HopCfgW-1:0]  hop_q;
  logic [GainCfgW-1:0] gain_q;

  logic          busy;
  logic          fq_valid, fq_ready, q_valid, q_pop;
  logic [AW-1:0] fq_addr, q_addr;
  cmd_t          fq_cmd, q_cmd;
  logic [QW-1:0] q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowRst;
      hop_q    <= HopRst;
      gain_q   <= GainRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWindow: window_q <= cfg_data_i[WinCfgW-1:0];
        CfgHop:    hop_q    <= cfg_data_i[HopCfgW-1:0];
        CfgGain:   gain_q   <= cfg_data_i[GainCfgW-1:0];
        default:   ;
      endcase
    end
  end

  oas_front #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .window_i     (window_q),
    .hop_i        (hop_q),
    .busy_i       (busy),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .q_ready_i    (fq_ready),
    .q_valid_o    (fq_valid),
    .q_addr_o     (fq_addr),
    .q_cmd_o      (fq_cmd)
  );

  oas_queue #(
    .Width(QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fq_valid),
    .push_ready_o(fq_ready),
    .push_data_i ({fq_addr, fq_cmd}),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  assign q_addr = q_data[QW-1:CmdW];
  assign q_cmd  = q_data[CmdW-1:0];

  oas_back #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gain_i       (gain_q),
    .busy_o       (busy),
    .q_valid_i    (q_valid),
    .q_addr_i     (q_addr),
    .q_cmd_i      (q_cmd),
    .q_pop_o      (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready)
    else $error("input accepted during store clear");

  a_clear_queue_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !q_valid)
    else $error("queue holds requests during store clear");

  a_accept_enqueued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> q_valid)
    else $error("accepted request missing from queue");

endmodule

`default_nettype wire

// ----- bench/oas_checker.sv -----
// Checker for overlap_add_synthesis: mirrors register writes, predicts the
// overlap-added hop samples of each accepted grain sample and compares them
// with the output stream. Depends on oas_pkg.
`timescale 1ns / 1ps

module oas_checker import oas_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire logic [SampleW-1:0]  in_data_i,   // [15:0] grain_sample
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire logic [SampleW-1:0]  out_data_i,  // [15:0] out_sample
  input  wire logic                out_last_i,  // end_of_hop
  output int                       mismatches_o,
  output int                       due_count_o
);

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last;
  } hop_out_t;

  hop_out_t                  hop_samples_due[$];
  logic signed [SampleW-1:0] overlap [MAX_WINDOW];
  int unsigned               position;
  int unsigned               base;
  logic [WinCfgW-1:0]        win_r;
  logic [HopCfgW-1:0]        hop_r;
  logic [GainCfgW-1:0]       gain_r;
  int                        errors = 0;

  function automatic logic signed [SampleW-1:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[SampleW-1:0];
  endfunction

  task automatic add_grain_sample(input logic [SampleW-1:0] din);
    int unsigned w;
    int unsigned h;
    int unsigned addr;
    longint      scaled;
    hop_out_t    r;
    w = win_r;
    if (w < 2) w = 2;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    h = hop_r;
    if (h < 1 || w < 2 * h) h = w / 2;
    if (position >= w) position = 0;
    if (base >= w) base = 0;
    // round half up: floor((s * g + 2^14) / 2^15)
    scaled = (longint'($signed(din)) * longint'(gain_r) + 64'sd16384) >>> 15;
    addr = base + position;
    if (addr >= w) addr -= w;
    if (position < h) begin
      r.sample = clip16(longint'(overlap[addr]) + scaled);
      r.last   = (position == h - 1);
      hop_samples_due.push_back(r);
      overlap[addr] = '0;
    end else begin
      overlap[addr] = clip16(longint'(overlap[addr]) + scaled);
    end
    position++;
    if (position >= w) begin
      position = 0;
      base += h;
      if (base >= w) base -= w;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hop_out_t head;
    if (!rst_ni) begin
      foreach (overlap[i]) overlap[i] = '0;
      position = 0;
      base     = 0;
      win_r    = WindowRst;
      hop_r    = HopRst;
      gain_r   = GainRst;
      hop_samples_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (hop_samples_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected output sample %h last %b", out_data_i, out_last_i);
          end
        end else begin
          head = hop_samples_due.pop_front();
          if (head.sample !== out_data_i || head.last !== out_last_i) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected sample %h last %b, got sample %h last %b",
                       head.sample, head.last, out_data_i, out_last_i);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgWindow: win_r  = cfg_data_i[WinCfgW-1:0];
          CfgHop:    hop_r  = cfg_data_i[HopCfgW-1:0];
          CfgGain:   gain_r = cfg_data_i[GainCfgW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) add_grain_sample(in_data_i);
    end
    mismatches_o = errors;
    due_count_o  = hop_samples_due.size();
  end

endmodule

// ----- bench/overlap_add_synthesis_test.sv -----
// Top of the overlap_add_synthesis bench: clock, reset, register setup,
// directed and random grain streams with idling phases, and the verdict.
// Depends on oas_pkg, overlap_add_synthesis and oas_checker.
`timescale 1ns / 1ps

module overlap_add_synthesis_test;
  import oas_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int Drain      = 16;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SampleW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [SampleW-1:0]  m_axis_tdata;
  logic                m_axis_tlast;

  int mismatches;
  int due_count;
  int send_idle  = 0;
  int recv_stall = 0;
  int cycle_count = 0;

  overlap_add_synthesis dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  oas_checker oas_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_last_i   (m_axis_tlast),
    .mismatches_o (mismatches),
    .due_count_o  (due_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 77; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 77; end
      default: begin send_idle = 9; recv_stall = 9; end
    endcase
  endtask

  // stop sending, then wait for every hop sample and for in-flight store updates
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (due_count != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic load_regs(input int w, input int h, input int g);
    settle();
    write_reg(CfgWindow, CfgDataW'(w));
    write_reg(CfgHop, CfgDataW'(h));
    write_reg(CfgGain, CfgDataW'(g));
  endtask

  task automatic push_sample(input int v);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= SampleW'(v);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic int pick_sample();
    case ($urandom_range(9))
      0: return 32767;
      1: return -32768;
      2, 3, 4: return int'($urandom_range(0, 511)) - 256;
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int pick_gain();
    case ($urandom_range(9))
      0: return 0;
      1: return 32768;
      2: return 65535;
      3: return int'($urandom_range(0, 65535));
      default: return int'($urandom_range(0, 32768));
    endcase
  endfunction

  initial begin
    int sent;
    int phase;
    int w;
    int we;
    int h;
    int n;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgWindow;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // store sweep after reset
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);

    // full-scale unity gain, saturation at the output
    load_regs(4, 2, 32768);
    push_sample(32767);
    push_sample(-32768);
    push_sample(32767);
    push_sample(32767);
    push_sample(1);
    push_sample(-32768);
    // half gain: rounding ties
    load_regs(4, 2, 16384);
    push_sample(1);
    push_sample(-1);
    push_sample(3);
    push_sample(-3);
    // window below minimum, gain above unity
    load_regs(0, 1, 65535);
    push_sample(32767);
    push_sample(-32768);
    push_sample(-32768);
    // window above maximum, zero hop, zero gain
    load_regs(4095, 0, 0);
    push_sample(12345);
    push_sample(-1);
    // hop more than half the window
    load_regs(8, 5, 32768);
    push_sample(1000);
    push_sample(-1000);
    push_sample(32767);
    push_sample(-32768);
    push_sample(7);
    // shrink window mid-grain
    load_regs(3, 1, 20000);
    push_sample(32767);
    push_sample(-32768);
    push_sample(555);
    push_sample(-555);

    sent  = 0;
    phase = 0;
    while (sent < 1200) begin
      if ($urandom_range(7) == 0) begin
        w = $urandom_range(1) ? 2048 : int'($urandom_range(1024, 4095));
        n = $urandom_range(40, 120);
      end else begin
        w = $urandom_range(0, 64);
        n = $urandom_range(40, 160);
      end
      we = (w < 2) ? 2 : ((w > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : w);
      case ($urandom_range(9))
        0: h = 0;
        1: h = $urandom_range(0, 2047);
        default: h = $urandom_range(1, we / 2);
      endcase
      load_regs(w, h, pick_gain());
      set_idling(phase % 4);
      repeat (n) push_sample(pick_sample());
      sent += n;
      phase++;
    end

    settle();
    if (mismatches == 0 && due_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
